// ===== design/utf8_to_legacy_8bit_charset_defines.svh =====
// Assertion helpers for the checks in the converter.
`ifndef UTF8_TO_LEGACY_8BIT_CHARSET_DEFINES_SVH
`define UTF8_TO_LEGACY_8BIT_CHARSET_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define U8LC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define U8LC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== design/u8lc_pkg.sv =====
`default_nettype none
package u8lc_pkg;

   localparam int GLYPH_COUNT = 128;
   localparam int HASH_BITS   = 9;

   // Configuration register indexes.
   localparam logic [0:0] CSR_CONVERT_ENABLE   = 1'd0;
   localparam logic [0:0] CSR_REPLACEMENT_CHAR = 1'd1;

   localparam logic [7:0] REPLACEMENT_RESET = 8'd64;

   // Code point of each upper-half character 128..255.
   localparam logic [15:0] GLYPH_CODE [GLYPH_COUNT] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h00DF, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h00E3, 16'h00F5, 16'h00D8, 16'h00F8, 16'h0153, 16'h0152, 16'h00C0, 16'h00C3,
      16'h00D5, 16'h00A8, 16'h00B4, 16'h2020, 16'h00B6, 16'h00A9, 16'h00AE, 16'h2122,
      16'h0133, 16'h0132, 16'h05D0, 16'h05D1, 16'h05D2, 16'h05D3, 16'h05D4, 16'h05D5,
      16'h05D6, 16'h05D7, 16'h05D8, 16'h05D9, 16'h05DB, 16'h05DC, 16'h05DE, 16'h05E0,
      16'h05E1, 16'h05E2, 16'h05E4, 16'h05E6, 16'h05E7, 16'h05E8, 16'h05E9, 16'h05EA,
      16'h05DF, 16'h05DA, 16'h05DD, 16'h05E3, 16'h05E5, 16'h00A7, 16'h2227, 16'h221E,
      16'h03B1, 16'h03B2, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h222E, 16'h03C6, 16'h2208, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h00B3, 16'h00AF
   };

   // A character owns its hash slot only if no later character shares the
   // same low code-point bits; later entries overwrite earlier ones.
   function automatic logic glyph_wins(input int k);
      logic wins;
      wins = 1'b1;
      for (int j = k + 1; j < GLYPH_COUNT; j++) begin
         if (GLYPH_CODE[j][HASH_BITS-1:0] == GLYPH_CODE[k][HASH_BITS-1:0]) begin
            wins = 1'b0;
         end
      end
      return wins;
   endfunction

   // Result of decoding one byte against the sequence state.
   typedef struct packed {
      logic        emit;        // a character completes with this byte
      logic        use_map;     // the character goes through the table
      logic [7:0]  direct_char; // character when the table is not used
      logic [15:0] code_point;  // code point to look up
      logic [1:0]  pending;     // next bytes_pending
      logic [15:0] accum;       // next code_accum
   } decode_type;

endpackage
`default_nettype wire

// ===== design/u8lc_decode.sv =====
`default_nettype none
module u8lc_decode (
   input  wire logic                 convert_enable,
   input  wire logic [7:0]           replacement_char,
   input  wire logic [7:0]           in_byte,
   input  wire logic [1:0]           pending,
   input  wire logic [15:0]          accum,
   output u8lc_pkg::decode_type      result
);
   import u8lc_pkg::*;

   logic [15:0] shifted;

   assign shifted = {accum[9:0], in_byte[5:0]};

   always_comb begin
      result             = '0;
      result.direct_char = in_byte;
      result.code_point  = {8'd0, in_byte};
      result.pending     = pending;
      result.accum       = accum;
      if (!convert_enable) begin
         // Bypass drops any partly gathered sequence.
         result.emit    = 1'b1;
         result.pending = 2'd0;
         result.accum   = 16'd0;
      end else if (pending != 2'd0) begin
         result.accum      = shifted;
         result.pending    = pending - 2'd1;
         result.code_point = shifted;
         result.emit       = (pending == 2'd1);
         result.use_map    = 1'b1;
      end else if (in_byte inside {[8'd0:8'd127]}) begin
         result.emit = 1'b1;
      end else if (in_byte inside {[8'd128:8'd191]}) begin
         result.emit        = 1'b1;
         result.direct_char = replacement_char;
      end else if (in_byte inside {[8'd192:8'd223]}) begin
         result.accum   = {11'd0, in_byte[4:0]};
         result.pending = 2'd1;
      end else if (in_byte inside {[8'd224:8'd239]}) begin
         result.accum   = {12'd0, in_byte[3:0]};
         result.pending = 2'd2;
      end else begin
         result.emit    = 1'b1;
         result.use_map = 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== design/u8lc_map.sv =====
`default_nettype none
module u8lc_map (
   input  wire logic [15:0] code_point,
   input  wire logic [7:0]  replacement_char,
   output logic [7:0]       out_char
);
   import u8lc_pkg::*;

   logic       hit;
   logic [6:0] index;

   // Each character compares against its own constant code point; at most
   // one can match, so the hits are simply merged.
   always_comb begin
      hit   = 1'b0;
      index = 7'd0;
      for (int k = 0; k < GLYPH_COUNT; k++) begin
         if (glyph_wins(k) && (code_point == GLYPH_CODE[k])) begin
            hit   = 1'b1;
            index = 7'(k);
         end
      end
   end

   assign out_char = hit ? {1'b1, index} : replacement_char;

endmodule
`default_nettype wire

// ===== design/utf8_to_legacy_8bit_charset.sv =====
`default_nettype none
// UTF-8 to 8-bit character set converter.
// The req channel carries one byte of UTF-8 text per item; the rsp channel
// carries one 8-bit character per completed character. Plain ASCII passes
// straight through, a stray continuation byte gives the replacement
// character, and two- and three-byte sequences are gathered and looked up
// against the upper-half table, giving index+128 or the replacement.
// Lead bytes of 240 and above are looked up as their own value.
// A byte that opens a sequence, or continues one without completing it, gives no rsp item.
// The csr port writes convert_enable (index 0) and replacement_char
// (index 1); clearing convert_enable copies bytes and drops a partial
// sequence. Write the registers only while the block is idle.
// An accepted byte is decoded and looked up in the input register, and the
// result is then loaded into the output register, which drives rsp_valid.
// Throughput is one byte per cycle, limited only by the output register.
// When the receiver stalls, the held result stays on rsp_out_char, the input
// register keeps its byte and req_stall rises once both stages are full.
// Reset (synchronous) empties both stages, clears the sequence state and
// restores convert_enable to 1 and replacement_char to 64.
module utf8_to_legacy_8bit_charset (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   input  wire logic       csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [7:0] csr_data
);
   import u8lc_pkg::*;

   `include "utf8_to_legacy_8bit_charset_defines.svh"

   // Configuration.
   logic       convert_enable_ff;
   logic [7:0] replacement_char_ff;

   // Input stage.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Sequence state.
   logic [1:0]  pending_ff,  pending_in;
   logic [15:0] accum_ff,    accum_in;

   // Output stage.
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff;

   decode_type decoded;
   logic [7:0] mapped_char;
   logic       advance;

   // The input stage moves on whenever the output register is free or is
   // being emptied in this cycle.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   u8lc_decode decode_unit (
      .convert_enable   (convert_enable_ff),
      .replacement_char (replacement_char_ff),
      .in_byte          (in_byte_ff),
      .pending          (pending_ff),
      .accum            (accum_ff),
      .result           (decoded)
   );

   u8lc_map map_unit (
      .code_point       (decoded.code_point),
      .replacement_char (replacement_char_ff),
      .out_char         (mapped_char)
   );

   always_comb begin
      pending_in   = pending_ff;
      accum_in     = accum_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (in_valid_ff && advance) begin
         pending_in   = decoded.pending;
         accum_in     = decoded.accum;
         out_valid_in = decoded.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         convert_enable_ff   <= 1'b1;
         replacement_char_ff <= REPLACEMENT_RESET;
         in_valid_ff         <= 1'b0;
         pending_ff          <= 2'd0;
         accum_ff            <= 16'd0;
         out_valid_ff        <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CONVERT_ENABLE:   convert_enable_ff   <= csr_data[0];
               CSR_REPLACEMENT_CHAR: replacement_char_ff <= csr_data;
               default: ;
            endcase
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         pending_ff   <= pending_in;
         accum_ff     <= accum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
      if (in_valid_ff && advance && decoded.emit) begin
         out_char_ff <= decoded.use_map ? mapped_char : decoded.direct_char;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_char = out_char_ff;

   // Back-pressure reaches the input only through a full, stalled output.
   `U8LC_ASSERT_NOW(stall_needs_full_output, clock, reset, req_stall,
                    rsp_valid && rsp_stall)
   // An accepted byte always lands in the input register.
   `U8LC_ASSERT_NEXT(accept_fills_input, clock, reset, req_valid && !req_stall,
                     in_valid_ff)
   // No sequence ever expects three continuation bytes.
   `U8LC_ASSERT_NOW(pending_in_range, clock, reset, 1'b1, pending_ff != 2'd3)
   // An ASCII byte outside a sequence comes out unchanged in the next cycle.
   `U8LC_ASSERT_NEXT(ascii_passes, clock, reset,
                     in_valid_ff && advance && convert_enable_ff &&
                     (pending_ff == 2'd0) && !in_byte_ff[7],
                     rsp_valid && (rsp_out_char == $past(in_byte_ff)))

endmodule
`default_nettype wire
